### rtl/core/edge_transition_projection_histogram_top_defines.svh
// ----------------------------------------------------------------------------
// Edge transition projection histogram: assertion macros
// Shared property shorthands for the checker of the top level.
// ----------------------------------------------------------------------------
`ifndef EDGE_TRANSITION_PROJECTION_HISTOGRAM_TOP_DEFINES_SVH
`define EDGE_TRANSITION_PROJECTION_HISTOGRAM_TOP_DEFINES_SVH

// Same-cycle implication, off while reset is high
`define ETPH_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("etph assertion failed");

// Next-cycle implication, off while reset is high
`define ETPH_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("etph assertion failed");

// Next-cycle implication that also holds across reset
`define ETPH_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("etph assertion failed");

`endif

### rtl/core/etph_pkg.sv
// ----------------------------------------------------------------------------
// etph_pkg
// Types, codes and helpers of the edge transition projection histogram.
// ----------------------------------------------------------------------------
package etph_pkg;

  // Field widths
  localparam int PIX_W    = 8;
  localparam int POS_W    = 10;
  localparam int CNT_W    = 10;
  localparam int SEL_W    = 10;
  localparam int CFG_W    = 11;
  localparam int CFG_IDX_W = 2;
  // Wide enough for any clamped frame size up to 4096
  localparam int SIZE_W   = 13;

  // Default size limits
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
  localparam logic [SIZE_W-1:0] MIN_SIZE = SIZE_W'(3);

  // Register reset values
  localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = CFG_W'(640);
  localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = CFG_W'(480);
  localparam logic [PIX_W-1:0] RST_DARK_LIMIT   = PIX_W'(15);
  localparam logic [PIX_W-1:0] RST_BRIGHT_LIMIT = PIX_W'(240);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DARK_LIMIT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_LIMIT = 2'd3;

  // Opcodes and result kinds
  localparam logic OP_PIXEL    = 1'b0;
  localparam logic OP_READ     = 1'b1;
  localparam logic KIND_ROW    = 1'b0;
  localparam logic KIND_COLUMN = 1'b1;

  // Item handed from the scan stage to the column stage
  typedef struct packed {
    logic             is_pixel;
    logic             has_result;
    logic             kind;
    logic [POS_W-1:0] position;
    logic [CNT_W-1:0] row_count;
    logic             frame_end;
    logic             clear;     // first row: column entry restarts at zero
    logic             col_en;    // interior pixel: vertical compare counts
    logic             sel_ok;    // read index inside the frame width
    logic [PIX_W-1:0] pixel;
  } etph_item_t;

  // One result beat
  typedef struct packed {
    logic             kind;
    logic [POS_W-1:0] position;
    logic [CNT_W-1:0] count;
    logic             frame_end;
  } etph_result_t;

  function automatic logic etph_is_transition(
    input logic [PIX_W-1:0] a,
    input logic [PIX_W-1:0] b,
    input logic [PIX_W-1:0] dark,
    input logic [PIX_W-1:0] bright
  );
    etph_is_transition = ((a <= dark) && (b >= bright)) ||
                         ((a >= bright) && (b <= dark));
  endfunction

  function automatic logic [CNT_W-1:0] etph_sat_inc(input logic [CNT_W-1:0] c);
    etph_sat_inc = (c == COUNT_MAX) ? c : c + 1'b1;
  endfunction

endpackage

### rtl/core/etph_ram.sv
// ----------------------------------------------------------------------------
// etph_ram
// Simple dual-port RAM, one write and one registered read port, read-first.
// ----------------------------------------------------------------------------
module etph_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

### rtl/core/etph_scan.sv
// ----------------------------------------------------------------------------
// etph_scan
// Raster position tracking and row transition count, first pipeline stage.
// ----------------------------------------------------------------------------
module etph_scan import etph_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  localparam int XW = $clog2(MAX_WIDTH),
  localparam int YW = $clog2(MAX_HEIGHT)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic              opcode,
  input  logic [PIX_W-1:0]  pixel_value,
  input  logic [SEL_W-1:0]  column_select,
  input  logic [SIZE_W-1:0] width_eff,
  input  logic [SIZE_W-1:0] height_eff,
  input  logic [PIX_W-1:0]  dark_limit,
  input  logic [PIX_W-1:0]  bright_limit,
  output etph_item_t        item,
  output logic [XW-1:0]     addr
);

  logic [XW-1:0]    column_position, column_position_next;
  logic [YW-1:0]    row_position, row_position_next;
  logic [PIX_W-1:0] left_pixel;
  logic [CNT_W-1:0] row_accumulator, row_accumulator_next;
  logic [CNT_W-1:0] acc_hit;
  logic             x_in, y_in, row_hit, row_end, last_row;

  // Interior test, row end and row count
  always_comb begin
    x_in     = (column_position != '0) &&
               (SIZE_W'(column_position) + SIZE_W'(2) <= width_eff);
    y_in     = (row_position != '0) &&
               (SIZE_W'(row_position) + SIZE_W'(2) <= height_eff);
    row_hit  = x_in && y_in &&
               etph_is_transition(left_pixel, pixel_value, dark_limit, bright_limit);
    acc_hit  = row_hit ? etph_sat_inc(row_accumulator) : row_accumulator;
    row_end  = (SIZE_W'(column_position) + SIZE_W'(1) >= width_eff);
    last_row = (SIZE_W'(row_position) + SIZE_W'(1) >= height_eff);
  end

  // Next position and accumulator
  always_comb begin
    column_position_next = column_position;
    row_position_next    = row_position;
    row_accumulator_next = row_accumulator;
    if (accept && (opcode == OP_PIXEL)) begin
      if (row_end) begin
        column_position_next = '0;
        row_position_next    = last_row ? '0 : row_position + 1'b1;
        row_accumulator_next = '0;
      end else begin
        column_position_next = column_position + 1'b1;
        row_accumulator_next = acc_hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_position <= '0;
      row_position    <= '0;
      row_accumulator <= '0;
      left_pixel      <= '0;
    end else begin
      column_position <= column_position_next;
      row_position    <= row_position_next;
      row_accumulator <= row_accumulator_next;
      if (accept && (opcode == OP_PIXEL)) begin
        left_pixel <= pixel_value;
      end
    end
  end

  // Item for the column stage; memory address is column or read index
  always_comb begin
    item.is_pixel  = (opcode == OP_PIXEL);
    item.pixel     = pixel_value;
    item.clear     = (row_position == '0);
    item.col_en    = x_in && y_in;
    item.sel_ok    = (SIZE_W'(column_select) < width_eff);
    item.row_count = acc_hit;
    if (opcode == OP_PIXEL) begin
      item.has_result = row_end;
      item.kind       = KIND_ROW;
      item.position   = POS_W'(row_position);
      item.frame_end  = last_row;
      addr            = column_position;
    end else begin
      item.has_result = 1'b1;
      item.kind       = KIND_COLUMN;
      item.position   = POS_W'(column_select);
      item.frame_end  = 1'b0;
      addr            = XW'(column_select);
    end
  end

endmodule

### rtl/core/etph_column.sv
// ----------------------------------------------------------------------------
// etph_column
// Line buffer and column count memory, read-modify-write second stage.
// ----------------------------------------------------------------------------
module etph_column import etph_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  localparam int XW = $clog2(MAX_WIDTH)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  etph_item_t       item,
  input  logic [XW-1:0]    addr,
  input  logic [PIX_W-1:0] dark_limit,
  input  logic [PIX_W-1:0] bright_limit,
  output logic             res_valid,
  output etph_result_t     res
);

  logic             b_valid;
  etph_item_t       b_item;
  logic [XW-1:0]    b_addr;
  logic             fwd;
  logic [CNT_W-1:0] fwd_data;
  logic [PIX_W-1:0] lb_rdata;
  logic [CNT_W-1:0] cnt_rdata, cnt_old, b_wdata;
  logic             b_we, hit;

  // Line buffer: read the pixel above and store the new one in one access.
  // Consecutive pixels never share a column, so no forwarding here.
  etph_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_buf (
    .clk   (clk),
    .we    (accept && item.is_pixel),
    .waddr (addr),
    .wdata (item.pixel),
    .raddr (addr),
    .rdata (lb_rdata)
  );

  // Column counts: read at accept, written back in the next cycle
  etph_ram #(.WIDTH(CNT_W), .DEPTH(MAX_WIDTH)) u_col_cnt (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_addr),
    .wdata (b_wdata),
    .raddr (addr),
    .rdata (cnt_rdata)
  );

  // Stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      fwd     <= 1'b0;
    end else begin
      b_valid <= accept;
      fwd     <= b_we && (b_addr == addr);
    end
    b_item   <= item;
    b_addr   <= addr;
    fwd_data <= b_wdata;
  end

  // Update: clear on the first row, bump on an interior vertical transition
  always_comb begin
    cnt_old = fwd ? fwd_data : cnt_rdata;
    hit     = b_item.col_en &&
              etph_is_transition(lb_rdata, b_item.pixel, dark_limit, bright_limit);
    b_we    = b_valid && b_item.is_pixel && (b_item.clear || hit);
    b_wdata = b_item.clear ? '0 : etph_sat_inc(cnt_old);
  end

  // Result beat
  always_comb begin
    res_valid     = b_valid && b_item.has_result;
    res.kind      = b_item.kind;
    res.position  = b_item.position;
    res.frame_end = b_item.frame_end;
    if (b_item.is_pixel) begin
      res.count = b_item.row_count;
    end else begin
      res.count = b_item.sel_ok ? cnt_old : '0;
    end
  end

endmodule

### rtl/core/etph_outq.sv
// ----------------------------------------------------------------------------
// etph_outq
// Three-entry result queue; holds off input when an in-flight beat has no room.
// ----------------------------------------------------------------------------
module etph_outq import etph_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  etph_result_t push_data,
  input  logic         out_stall,
  output logic         out_valid,
  output etph_result_t out_data,
  output logic         in_stall
);

  localparam int DEPTH = 3;
  localparam int PW    = $clog2(DEPTH);

  etph_result_t     entries [DEPTH];
  logic [PW-1:0]    wr_ptr, rd_ptr;
  logic [PW:0]      level, level_next;
  logic             pop;

  // Pointer wrap
  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign out_valid = (level != '0);
  assign out_data  = entries[rd_ptr];
  assign pop       = out_valid && !out_stall;
  // An item accepted now pushes in the cycle after the beat now in the column stage
  assign in_stall  = ((PW+1)'(level) + (PW+1)'(push)) >= (PW+1)'(DEPTH);

  always_comb begin
    level_next = level + (PW+1)'(push) - (PW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      level <= level_next;
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
    end
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

### rtl/core/edge_transition_projection_histogram_top.sv
// ----------------------------------------------------------------------------
// edge_transition_projection_histogram_top
// Row and column dark/bright transition profile of a raster pixel stream.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_stall  | opcode, pixel_value, column_select
//  out     | out_valid / out_stall| result_kind, position, transition_count,
//          |                      | frame_end
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  One beat per cycle sustained while in_stall is low. The column count memory
//  is read at accept and written back the next cycle, with forwarding into a
//  read that follows. Results pass the stage register into a 3-entry queue.
//  Reset (rst, synchronous) clears positions and queue; memories need no clear,
//  every column entry is rewritten as zero during the first row of a frame.
//  in_stall rises only when the queue cannot hold a beat still in flight.
// ----------------------------------------------------------------------------
module edge_transition_projection_histogram_top import etph_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                 clk,
  input  logic                 rst,
  // input beats
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 opcode,
  input  logic [PIX_W-1:0]     pixel_value,
  input  logic [SEL_W-1:0]     column_select,
  // result beats
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 result_kind,
  output logic [POS_W-1:0]     position,
  output logic [CNT_W-1:0]     transition_count,
  output logic                 frame_end,
  // register writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int XW = $clog2(MAX_WIDTH);

  logic [CFG_W-1:0]  frame_width, frame_height;
  logic [PIX_W-1:0]  dark_limit, bright_limit;
  logic [SIZE_W-1:0] width_eff, height_eff;
  logic              accept;
  etph_item_t        item;
  logic [XW-1:0]     addr;
  logic              res_valid;
  etph_result_t      res, out_data;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= RST_FRAME_WIDTH;
      frame_height <= RST_FRAME_HEIGHT;
      dark_limit   <= RST_DARK_LIMIT;
      bright_limit <= RST_BRIGHT_LIMIT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        REG_DARK_LIMIT:   dark_limit   <= cfg_data[PIX_W-1:0];
        REG_BRIGHT_LIMIT: bright_limit <= cfg_data[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // Frame size clamped to the supported range
  always_comb begin
    if (SIZE_W'(frame_width) < MIN_SIZE) begin
      width_eff = MIN_SIZE;
    end else if (SIZE_W'(frame_width) > SIZE_W'(MAX_WIDTH)) begin
      width_eff = SIZE_W'(MAX_WIDTH);
    end else begin
      width_eff = SIZE_W'(frame_width);
    end
    if (SIZE_W'(frame_height) < MIN_SIZE) begin
      height_eff = MIN_SIZE;
    end else if (SIZE_W'(frame_height) > SIZE_W'(MAX_HEIGHT)) begin
      height_eff = SIZE_W'(MAX_HEIGHT);
    end else begin
      height_eff = SIZE_W'(frame_height);
    end
  end

  assign accept = in_valid && !in_stall;

  etph_scan #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_scan (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .opcode        (opcode),
    .pixel_value   (pixel_value),
    .column_select (column_select),
    .width_eff     (width_eff),
    .height_eff    (height_eff),
    .dark_limit    (dark_limit),
    .bright_limit  (bright_limit),
    .item          (item),
    .addr          (addr)
  );

  etph_column #(.MAX_WIDTH(MAX_WIDTH)) u_column (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .item         (item),
    .addr         (addr),
    .dark_limit   (dark_limit),
    .bright_limit (bright_limit),
    .res_valid    (res_valid),
    .res          (res)
  );

  etph_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .in_stall  (in_stall)
  );

  assign result_kind      = out_data.kind;
  assign position         = out_data.position;
  assign transition_count = out_data.count;
  assign frame_end        = out_data.frame_end;

endmodule

### rtl/core/etph_checker.sv
// ----------------------------------------------------------------------------
// etph_checker
// Port-level checks of the edge transition projection histogram.
// ----------------------------------------------------------------------------
`include "edge_transition_projection_histogram_top_defines.svh"

module etph_checker import etph_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             out_valid,
  input logic             out_stall,
  input logic             result_kind,
  input logic [POS_W-1:0] position,
  input logic [CNT_W-1:0] transition_count,
  input logic             frame_end
);

  logic row_beat, col_beat;

  // Result beat kinds on offer
  assign row_beat = out_valid && (result_kind == KIND_ROW);
  assign col_beat = out_valid && (result_kind == KIND_COLUMN);

  // A stalled result beat stays offered
  `ETPH_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)

  // Column reads never close a frame
  `ETPH_ASSERT_NOW(a_col_no_frame_end, clk, rst, col_beat, !frame_end)

  // The top border row never counts transitions
  `ETPH_ASSERT_NOW(a_row0_zero, clk, rst, row_beat && (position == '0), transition_count == '0)

  // Nothing is offered right after reset
  `ETPH_ASSERT_NEXT_ALWAYS(a_reset_quiet, clk, rst, !out_valid)

endmodule

bind edge_transition_projection_histogram_top etph_checker u_etph_checker (.*);

### tb/edge_transition_projection_histogram_top_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge transition projection histogram: result checker
// Watches the input, result and register channels of the block. It keeps its
// own copy of the raster position, line buffer and column counts, works out
// the result each input beat causes, and compares every result beat in order.
// ----------------------------------------------------------------------------
module edge_transition_projection_histogram_top_checker import etph_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic                 opcode,
  input  logic [PIX_W-1:0]     pixel_value,
  input  logic [SEL_W-1:0]     column_select,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic                 result_kind,
  input  logic [POS_W-1:0]     position,
  input  logic [CNT_W-1:0]     transition_count,
  input  logic                 frame_end,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   mismatches,
  output int                   pending,
  output int                   rows_checked,
  output int                   reads_checked
);

  localparam int REPORT_LIMIT = 10;

  // register copies
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  logic [PIX_W-1:0] dark_reg;
  logic [PIX_W-1:0] bright_reg;

  // raster scan state
  int unsigned      scan_x;
  int unsigned      scan_y;
  logic [PIX_W-1:0] left_px;
  logic [CNT_W-1:0] row_acc;
  logic [PIX_W-1:0] line_buf [DEF_MAX_WIDTH];
  logic [CNT_W-1:0] col_count [DEF_MAX_WIDTH];

  etph_result_t expected_counts [$];
  int fail_n;
  int row_n;
  int read_n;

  initial begin
    mismatches    = 0;
    pending       = 0;
    rows_checked  = 0;
    reads_checked = 0;
    fail_n        = 0;
    row_n         = 0;
    read_n        = 0;
  end

  // frame sizes outside the supported range saturate
  function automatic int unsigned clamp_size(input logic [CFG_W-1:0] v,
                                             input int unsigned upper);
    if (v < 3) return 3;
    if (v > upper) return upper;
    return v;
  endfunction

  // dark to bright or bright to dark; counts once even if both hold
  function automatic logic sharp_step(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b);
    return ((a <= dark_reg) && (b >= bright_reg)) || ((a >= bright_reg) && (b <= dark_reg));
  endfunction

  // advance the scan by one input beat and queue the result it causes
  task automatic project_transitions(input logic op, input logic [PIX_W-1:0] pix,
                                     input logic [SEL_W-1:0] sel);
    int unsigned  w;
    int unsigned  h;
    int unsigned  x;
    int unsigned  y;
    logic         x_in;
    logic         y_in;
    etph_result_t r;
    w = clamp_size(width_reg, DEF_MAX_WIDTH);
    h = clamp_size(height_reg, DEF_MAX_HEIGHT);
    if (op == OP_READ) begin
      r.kind      = KIND_COLUMN;
      r.position  = sel;
      r.count     = (sel < w) ? col_count[sel] : '0;
      r.frame_end = 1'b0;
      expected_counts.push_back(r);
    end else begin
      x    = scan_x;
      y    = scan_y;
      x_in = (x >= 1) && (x + 2 <= w);
      y_in = (y >= 1) && (y + 2 <= h);
      // column store: cleared in the first row, vertical compare elsewhere
      if (x < DEF_MAX_WIDTH) begin
        if (y == 0) begin
          col_count[x] = '0;
        end else if (x_in && y_in && sharp_step(line_buf[x], pix) &&
                     col_count[x] != COUNT_MAX) begin
          col_count[x] = col_count[x] + 1'b1;
        end
        line_buf[x] = pix;
      end
      // horizontal compare against the left neighbor
      if (x_in && y_in && sharp_step(left_px, pix) && row_acc != COUNT_MAX) begin
        row_acc = row_acc + 1'b1;
      end
      left_px = pix;
      // row closes: emit its count and wrap
      if (x + 1 >= w) begin
        r.kind      = KIND_ROW;
        r.position  = POS_W'(y);
        r.count     = row_acc;
        r.frame_end = (y + 1 >= h);
        expected_counts.push_back(r);
        row_acc = '0;
        scan_x  = 0;
        scan_y  = (y + 1 >= h) ? 0 : y + 1;
      end else begin
        scan_x = x + 1;
      end
    end
  endtask

  // sample all channels at the edge, predict first, then compare
  always @(posedge clk) begin
    etph_result_t got;
    etph_result_t want;
    int           i;
    if (rst) begin
      width_reg  = RST_FRAME_WIDTH;
      height_reg = RST_FRAME_HEIGHT;
      dark_reg   = RST_DARK_LIMIT;
      bright_reg = RST_BRIGHT_LIMIT;
      scan_x     = 0;
      scan_y     = 0;
      left_px    = '0;
      row_acc    = '0;
      for (i = 0; i < DEF_MAX_WIDTH; i++) begin
        line_buf[i]  = '0;
        col_count[i] = '0;
      end
      expected_counts.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FRAME_WIDTH:  width_reg  = cfg_data;
          REG_FRAME_HEIGHT: height_reg = cfg_data;
          REG_DARK_LIMIT:   dark_reg   = cfg_data[PIX_W-1:0];
          REG_BRIGHT_LIMIT: bright_reg = cfg_data[PIX_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        project_transitions(opcode, pixel_value, column_select);
      end
      if (out_valid && !out_stall) begin
        got.kind      = result_kind;
        got.position  = position;
        got.count     = transition_count;
        got.frame_end = frame_end;
        if (expected_counts.size() == 0) begin
          if (fail_n < REPORT_LIMIT) begin
            $display("%0t: result beat with none outstanding: kind %0d pos %0d count %0d end %0d",
                     $time, got.kind, got.position, got.count, got.frame_end);
          end
          fail_n++;
        end else begin
          want = expected_counts.pop_front();
          if (got.kind != want.kind || got.position != want.position ||
              got.count != want.count || got.frame_end != want.frame_end) begin
            if (fail_n < REPORT_LIMIT) begin
              $display("%0t: result mismatch: expected kind %0d pos %0d count %0d end %0d",
                       $time, want.kind, want.position, want.count, want.frame_end);
              $display("%0t:                   actual kind %0d pos %0d count %0d end %0d",
                       $time, got.kind, got.position, got.count, got.frame_end);
            end
            fail_n++;
          end
          if (want.kind == KIND_ROW) row_n++;
          else read_n++;
        end
      end
    end
    mismatches    <= fail_n;
    pending       <= expected_counts.size();
    rows_checked  <= row_n;
    reads_checked <= read_n;
  end

endmodule

### tb/edge_transition_projection_histogram_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge transition projection histogram: testbench top
// Streams raster pixels and column reads into the block under changing frame
// sizes and limits, with random idle and stall bursts, and gives the verdict
// from the checker's mismatch count and outstanding results.
// ----------------------------------------------------------------------------
module edge_transition_projection_histogram_top_tb;
  import etph_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 16;
  localparam int WIDE_ITEMS     = 100;
  localparam int RANDOM_ITEMS   = 620;
  localparam int CALM_ITEMS     = 120;

  logic                 clk;
  logic                 rst              = 1'b1;
  logic                 in_valid         = 1'b0;
  logic                 in_stall;
  logic                 opcode           = OP_PIXEL;
  logic [PIX_W-1:0]     pixel_value      = '0;
  logic [SEL_W-1:0]     column_select    = '0;
  logic                 out_valid;
  logic                 out_stall        = 1'b0;
  logic                 result_kind;
  logic [POS_W-1:0]     position;
  logic [CNT_W-1:0]     transition_count;
  logic                 frame_end;
  logic                 cfg_valid        = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index        = REG_FRAME_WIDTH;
  logic [CFG_W-1:0]     cfg_data         = '0;

  int mismatches;
  int pending;
  int rows_checked;
  int reads_checked;

  // raster position as the stimulus sees it, to keep reads and size
  // changes away from store entries that were never written
  logic [CFG_W-1:0] width_set;
  logic [CFG_W-1:0] height_set;
  int unsigned      cur_x;
  int unsigned      cur_y;
  int unsigned      line_span;
  bit               col_seen [DEF_MAX_WIDTH];

  bit bursty_in;
  bit bursty_out;
  bit calm;
  int pixel_beats;
  int read_beats;
  int reg_writes;
  int random_sent;
  int stall_left = 0;
  int idle_count = 0;

  edge_transition_projection_histogram_top DUT (.*);

  edge_transition_projection_histogram_top_checker count_checker (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // random result side stall bursts
  always @(posedge clk) begin
    if (rst || calm || !bursty_out) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 5);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog: cycles without any beat on any channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_count <= 0;
    end else if (idle_count >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d results outstanding",
               idle_count, pending);
      $display("simulation failed");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  function automatic int unsigned eff_size(input logic [CFG_W-1:0] v);
    if (v < 3) return 3;
    if (v > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
    return v;
  endfunction

  // mostly near black or near white so that transitions are common
  function automatic logic [PIX_W-1:0] pick_pixel();
    case ($urandom_range(0, 4))
      0, 1:    return PIX_W'($urandom_range(0, 20));
      2, 3:    return PIX_W'($urandom_range(235, 255));
      default: return PIX_W'($urandom);
    endcase
  endfunction

  // a column inside the frame that has been written, or one outside it
  function automatic logic [SEL_W-1:0] pick_column();
    int unsigned c;
    if ($urandom_range(0, 1) == 1) c = $urandom_range(0, eff_size(width_set) - 1);
    else c = $urandom_range(0, DEF_MAX_WIDTH - 1);
    if (c < eff_size(width_set) && !col_seen[c]) c = 0;
    return SEL_W'(c);
  endfunction

  // one input beat, with an optional idle burst ahead of it
  task automatic send_beat(input logic op, input logic [PIX_W-1:0] pix,
                           input logic [SEL_W-1:0] sel);
    int gap;
    if (bursty_in && !calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    opcode        <= op;
    pixel_value   <= pix;
    column_select <= sel;
    do @(posedge clk); while (in_stall);
    // beat taken at this edge
    if (op == OP_PIXEL) begin
      pixel_beats++;
      if (cur_y == 0) col_seen[cur_x] = 1'b1;
      if (cur_x + 1 > line_span) line_span = cur_x + 1;
      if (cur_x + 1 >= eff_size(width_set)) begin
        cur_x = 0;
        cur_y = (cur_y + 1 >= eff_size(height_set)) ? 0 : cur_y + 1;
      end else begin
        cur_x++;
      end
    end else begin
      read_beats++;
    end
  endtask

  // leaves cfg_valid high; configure lowers it after the last write
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    reg_writes++;
    if (idx == REG_FRAME_WIDTH) width_set = val;
    if (idx == REG_FRAME_HEIGHT) height_set = val;
  endtask

  task automatic configure(input logic [CFG_W-1:0] w_val, input logic [CFG_W-1:0] h_val,
                           input logic [PIX_W-1:0] d_val, input logic [PIX_W-1:0] b_val,
                           input logic [3:0] mask);
    if (mask[0]) write_register(REG_FRAME_WIDTH, w_val);
    if (mask[1]) write_register(REG_FRAME_HEIGHT, h_val);
    if (mask[2]) write_register(REG_DARK_LIMIT, CFG_W'(d_val));
    if (mask[3]) write_register(REG_BRIGHT_LIMIT, CFG_W'(b_val));
    cfg_valid <= 1'b0;
  endtask

  // stop sending, let every result drain and the pipeline settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // new settings, possibly mid-frame, then a run of pixels and reads
  task automatic run_phase(input int unsigned items);
    int unsigned      k;
    logic [3:0]       mask;
    logic [CFG_W-1:0] w_val;
    logic [CFG_W-1:0] h_val;
    logic [PIX_W-1:0] d_val;
    logic [PIX_W-1:0] b_val;
    wait_idle();
    bursty_in  = ($urandom_range(0, 9) < 7);
    bursty_out = ($urandom_range(0, 9) < 7);
    mask = 4'($urandom_range(1, 15));
    // sizes mostly tiny; the saturating extremes now and then
    w_val = ($urandom_range(0, 19) == 0) ? 11'h7FF : 11'($urandom_range(0, 12));
    h_val = ($urandom_range(0, 19) == 0) ? 11'h7FF : 11'($urandom_range(0, 8));
    // past the first row, never widen beyond columns the line buffer holds
    if (mask[0] && cur_y != 0 && eff_size(w_val) > line_span) w_val = CFG_W'(line_span);
    case ($urandom_range(0, 4))
      0: begin d_val = RST_DARK_LIMIT; b_val = RST_BRIGHT_LIMIT; end
      1: begin d_val = 8'h00; b_val = 8'hFF; end
      2: begin d_val = 8'hFF; b_val = 8'h00; end
      3: begin d_val = PIX_W'($urandom); b_val = PIX_W'($urandom); end
      default: begin
        // overlapping limits: dark at or above bright
        d_val = PIX_W'($urandom_range(100, 255));
        b_val = PIX_W'($urandom_range(0, d_val));
      end
    endcase
    configure(w_val, h_val, d_val, b_val, mask);
    for (k = 0; k < items && random_sent < RANDOM_ITEMS; k++) begin
      calm = (random_sent >= RANDOM_ITEMS - CALM_ITEMS);
      if ($urandom_range(0, 9) == 0) send_beat(OP_READ, PIX_W'($urandom), pick_column());
      else send_beat(OP_PIXEL, pick_pixel(), SEL_W'($urandom));
      random_sent++;
    end
  endtask

  initial begin
    int unsigned x;
    int unsigned y;
    int unsigned k;
    width_set   = RST_FRAME_WIDTH;
    height_set  = RST_FRAME_HEIGHT;
    cur_x       = 0;
    cur_y       = 0;
    line_span   = 0;
    bursty_in   = 1'b1;
    bursty_out  = 1'b1;
    calm        = 1'b0;
    pixel_beats = 0;
    read_beats  = 0;
    reg_writes  = 0;
    random_sent = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // 5x4 checkerboard of black and white closed by a white row, then
    // reads of border, interior and out-of-range columns
    configure(11'd5, 11'd4, RST_DARK_LIMIT, RST_BRIGHT_LIMIT, 4'b1111);
    for (y = 0; y < 4; y++) begin
      for (x = 0; x < 5; x++) begin
        send_beat(OP_PIXEL, (y == 3 || (x + y) % 2 == 1) ? 8'hFF : 8'h00, SEL_W'($urandom));
      end
    end
    send_beat(OP_READ, PIX_W'($urandom), 10'd0);
    send_beat(OP_READ, PIX_W'($urandom), 10'd1);
    send_beat(OP_READ, PIX_W'($urandom), 10'd2);
    send_beat(OP_READ, PIX_W'($urandom), 10'd3);
    send_beat(OP_READ, PIX_W'($urandom), 10'h3FF);
    wait_idle();

    // widest frame (width saturates): the start of its first row, reads sprinkled in
    configure(11'h7FF, 11'd3, RST_DARK_LIMIT, RST_BRIGHT_LIMIT, 4'b0011);
    for (k = 0; k < WIDE_ITEMS; k++) begin
      if (k % 50 == 49) send_beat(OP_READ, PIX_W'($urandom), pick_column());
      else send_beat(OP_PIXEL, pick_pixel(), SEL_W'($urandom));
    end

    // random phases; the tail runs without idling
    while (random_sent < RANDOM_ITEMS) run_phase($urandom_range(20, 60));

    calm = 1'b1;
    wait_idle();
    $display("run covered %0d pixel beats and %0d column reads under %0d register writes",
             pixel_beats, read_beats, reg_writes);
    $display("%0d row counts and %0d column counts compared, %0d left outstanding",
             rows_checked, reads_checked, pending);
    if (mismatches == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
